FILE: design/prp_pkg.sv
// Shared constants, codes and command type of the priority round-robin picker.
package prp_pkg;

   localparam int NUM_ENTRIES_DEF  = 64;
   localparam int PRIORITY_MAX_DEF = 15;

   // Field widths of the request and response words
   localparam int ENTRY_IDX_W = 6;
   localparam int PRIO_W      = 4;
   localparam int OUTCOME_W   = 2;
   // Scan start is current_index + 1 before wrapping, so it needs one more bit
   localparam int START_W     = ENTRY_IDX_W + 1;
   // Table word: runnable flag above the priority
   localparam int ENTRY_W     = PRIO_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int IDLE_ENTRY  = 0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_SCHED = 1'b1
   } opcode_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_TASK = 2'd0,
      OUTCOME_IDLE = 2'd1,
      OUTCOME_NONE = 2'd2
   } outcome_type;

   // Classified command handed from the front end to the scan engine
   typedef struct packed {
      logic                   is_sched;
      logic                   wr_ok;
      logic [ENTRY_IDX_W-1:0] index;
      logic                   runnable;
      logic [PRIO_W-1:0]      prio;
      logic [START_W-1:0]     start;
   } cmd_type;

endpackage

FILE: design/prp_if.sv
// Valid/ready channel interfaces for request and response words.
interface prp_req_if import prp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic                   entry_runnable;
   logic [PRIO_W-1:0]      entry_priority;
   logic                   current_valid;
   logic [ENTRY_IDX_W-1:0] current_index;

   modport source (
      output valid, opcode, entry_index, entry_runnable, entry_priority,
             current_valid, current_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, entry_runnable, entry_priority,
             current_valid, current_index,
      output ready
   );
endinterface

interface prp_rsp_if import prp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ENTRY_IDX_W-1:0] chosen_index;
   logic [OUTCOME_W-1:0]   outcome;

   modport source (
      output valid, chosen_index, outcome,
      input  ready
   );
   modport sink (
      input  valid, chosen_index, outcome,
      output ready
   );
endinterface

FILE: design/prp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prp_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/prp_front.sv
// Front end: takes request words, saturates priorities and reduces the scan start.
module prp_front import prp_pkg::*; #(
   parameter int NUM_ENTRIES  = NUM_ENTRIES_DEF,
   parameter int PRIORITY_MAX = PRIORITY_MAX_DEF
) (
   input  logic     clock,
   input  logic     reset,
   prp_req_if.sink  req,
   input  logic     clear_busy,
   output logic     push_valid,
   output cmd_type  push_cmd,
   input  logic     push_ready
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int CMP_W = (START_W > IDX_W + 1) ? START_W : IDX_W + 1;

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    start_big;
   logic    norm_done;
   logic    push_now;
   logic    take;
   logic [ENTRY_IDX_W-1:0] cur_eff;
   logic [PRIO_W-1:0]      prio_sat;

   // Start still at or above table size: one subtract per cycle until it wraps in
   assign start_big  = CMP_W'(cmd_ff.start) >= CMP_W'(NUM_ENTRIES);
   assign norm_done  = !cmd_ff.is_sched || !start_big;
   assign push_valid = vld_ff && norm_done;
   assign push_cmd   = cmd_ff;
   assign push_now   = push_valid && push_ready;

   // Hold off new words while the table is being cleared
   assign req.ready = !clear_busy && (!vld_ff || push_now);
   assign take      = req.valid && req.ready;

   // No running task means the scan begins right after the idle entry
   assign cur_eff  = req.current_valid ? req.current_index : '0;
   assign prio_sat = (int'(req.entry_priority) > PRIORITY_MAX) ?
                     PRIO_W'(PRIORITY_MAX) : req.entry_priority;

   always_comb begin
      vld_in = vld_ff;
      cmd_in = cmd_ff;
      if (push_now) begin
         vld_in = 1'b0;
      end
      if (vld_ff && !norm_done) begin
         cmd_in.start = cmd_ff.start - START_W'(NUM_ENTRIES);
      end
      if (take) begin
         vld_in          = 1'b1;
         cmd_in.is_sched = (req.opcode == OP_SCHED);
         cmd_in.wr_ok    = CMP_W'(req.entry_index) < CMP_W'(NUM_ENTRIES);
         cmd_in.index    = req.entry_index;
         cmd_in.runnable = req.entry_runnable;
         cmd_in.prio     = prio_sat;
         cmd_in.start    = START_W'(cur_eff) + START_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

FILE: design/prp_queue.sv
// Short command queue between the front end and the scan engine.
module prp_queue import prp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/prp_back.sv
// Scan engine: owns the task table, applies writes and runs the round-robin scan.
module prp_back import prp_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  cmd_type   pop_cmd,
   output logic      pop_ready,
   prp_rsp_if.source rsp,
   output logic      clear_busy
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]      best_prio_ff, best_prio_in;
   logic                   idle_run_ff, idle_run_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [ENTRY_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   outcome_type            rsp_outcome_ff, rsp_outcome_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               rd_run;
   logic [PRIO_W-1:0]  rd_prio;

   prp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_run  = rd_data[ENTRY_W-1];
   assign rd_prio = rd_data[PRIO_W-1:0];

   assign clear_busy     = (state_ff == ST_CLEAR);
   assign rsp.valid      = rsp_vld_ff;
   assign rsp.chosen_index = rsp_idx_ff;
   assign rsp.outcome    = rsp_outcome_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      addr_in        = addr_ff;
      rd_vld_in      = 1'b0;
      rd_last_in     = 1'b0;
      rd_idx_in      = addr_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      idle_run_in    = idle_run_ff;
      rsp_vld_in     = rsp_vld_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_outcome_in = rsp_outcome_ff;
      wr_en          = 1'b0;
      wr_addr        = cnt_ff;
      wr_data        = '0;
      rd_en          = 1'b0;
      pop_ready      = 1'b0;

      if (rsp_vld_ff && rsp.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         // Zero the table one entry per cycle after reset
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         // Apply a write, or load a scan
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_cmd.is_sched) begin
                  addr_in      = IDX_W'(pop_cmd.start);
                  cnt_in       = '0;
                  found_in     = 1'b0;
                  best_idx_in  = '0;
                  best_prio_in = '0;
                  idle_run_in  = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  wr_en   = pop_cmd.wr_ok;
                  wr_addr = IDX_W'(pop_cmd.index);
                  wr_data = {pop_cmd.runnable, pop_cmd.prio};
               end
            end
         end
         // Issue one table read per cycle, wrapping at the last entry
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_vld_in  = 1'b1;
            rd_last_in = (cnt_ff == LAST_IDX);
            addr_in    = (addr_ff == LAST_IDX) ? '0 : addr_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_WAIT;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         // Last read data is being compared
         ST_WAIT: begin
            if (rd_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         // Load the response register once it is free
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in = 1'b1;
               if (found_ff) begin
                  rsp_idx_in     = ENTRY_IDX_W'(best_idx_ff);
                  rsp_outcome_in = OUTCOME_TASK;
               end else if (idle_run_ff) begin
                  rsp_idx_in     = ENTRY_IDX_W'(IDLE_ENTRY);
                  rsp_outcome_in = OUTCOME_IDLE;
               end else begin
                  rsp_idx_in     = '0;
                  rsp_outcome_in = OUTCOME_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Compare the entry read last cycle; strictly greater keeps the first in scan order
      if (rd_vld_ff) begin
         if (rd_idx_ff == IDX_W'(IDLE_ENTRY)) begin
            idle_run_in = rd_run;
         end else if (rd_run && (!found_ff || rd_prio > best_prio_ff)) begin
            found_in     = 1'b1;
            best_idx_in  = rd_idx_ff;
            best_prio_in = rd_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      addr_ff        <= addr_in;
      rd_idx_ff      <= rd_idx_in;
      found_ff       <= found_in;
      best_idx_ff    <= best_idx_in;
      best_prio_ff   <= best_prio_in;
      idle_run_ff    <= idle_run_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

endmodule

FILE: design/priority_round_robin_picker_top.sv
// Top level of the priority round-robin task picker.
// Keeps a table of NUM_ENTRIES task entries (runnable flag, priority). A write word
// (opcode 0) updates one entry and returns nothing; a schedule word (opcode 1) returns
// one response word naming the highest-priority runnable task, scanning from just after
// the current task and wrapping, with ties going to the first entry met and entry 0
// reserved as the idle task. The front end accepts a word per cycle into a two-deep
// command queue while that queue has room; a schedule request holds the scan engine
// until its scan ends, because the table is a single-read-port RAM read one entry
// per cycle. A schedule word whose current_index is beyond a small table has its start
// wrapped in the front end by repeated subtraction of NUM_ENTRIES. After reset the table
// is zeroed by a pass over all NUM_ENTRIES entries, during which req.ready stays low.
module priority_round_robin_picker_top import prp_pkg::*; #(
   parameter int NUM_ENTRIES  = NUM_ENTRIES_DEF,
   parameter int PRIORITY_MAX = PRIORITY_MAX_DEF
) (
   input  logic      clock,
   input  logic      reset,
   prp_req_if.sink   req,
   prp_rsp_if.source rsp
);

   logic    clear_busy;
   logic    push_valid;
   cmd_type push_cmd;
   logic    push_ready;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop_ready;

   // Accept and classify request words
   prp_front #(
      .NUM_ENTRIES  (NUM_ENTRIES),
      .PRIORITY_MAX (PRIORITY_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Decouple front end from scan engine
   prp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // Table writes and scans
   prp_back #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready),
      .rsp        (rsp),
      .clear_busy (clear_busy)
   );

   // No word taken while the table is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req.ready)
      else $error("request accepted during table clear");

   // Queue is never drained while the clear pass still owns the table
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> !clear_busy)
      else $error("command popped during table clear");

   // A stalled command in the front end is held unchanged
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> (push_valid && $stable(push_cmd)))
      else $error("front end dropped or changed a stalled command");

   // Idle and empty outcomes always report entry zero
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.outcome != OUTCOME_TASK) |-> (rsp.chosen_index == '0))
      else $error("non-task outcome with nonzero index");

endmodule
